FILE: rtl/c64id_pkg.sv
// shared types, constants and helper functions of the crc-64 disc id engine
`default_nettype none

package c64id_pkg;

    localparam logic [63:0] CRC_POLY    = 64'h92C6_4265_D321_39A4;
    localparam logic [63:0] CRC_INIT    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          ID_CHARS    = 17;
    localparam int          HYPHEN_POS  = 8;
    localparam int          MAX_BYTES   = 8;
    localparam logic [3:0]  DIGIT_LIMIT = 4'hA;
    localparam logic [6:0]  CHAR_ZERO   = 7'h30;
    localparam logic [6:0]  CHAR_A      = 7'h41;
    localparam logic [6:0]  CHAR_HYPHEN = 7'h2D;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

    // command from the input register to the accumulator
    typedef struct packed {
        logic       en;
        t_kind      kind;
        logic [3:0] count;
    } t_crc_cmd;

    // one byte into a reflected crc, bitwise
    function automatic logic [63:0] fold_byte(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] a;
        a = acc ^ {56'd0, b};
        for (int i = 0; i < 8; i++) begin
            a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < DIGIT_LIMIT) begin
            c = CHAR_ZERO + {3'd0, nib};
        end else begin
            c = CHAR_A + {3'd0, nib - DIGIT_LIMIT};
        end
        return c;
    endfunction

    // character at a given position of the formatted id
    function automatic logic [6:0] fmt_char(input logic [63:0] id, input logic [4:0] pos);
        logic [4:0] d5;
        logic [3:0] d;
        logic [3:0] nib;
        logic [6:0] c;
        d5  = (pos > 5'(HYPHEN_POS)) ? (pos - 5'd1) : pos;
        d   = d5[3:0];
        nib = 4'(id >> {~d, 2'b00});
        if (pos == 5'(HYPHEN_POS)) begin
            c = CHAR_HYPHEN;
        end else begin
            c = hex_char(nib);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/c64id_crc.sv
// crc-64 accumulator with an unrolled fold of up to eight bytes
`default_nettype none

module c64id_crc (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire c64id_pkg::t_crc_cmd  i_cmd,
    input  wire logic [63:0]          i_word,
    output logic [63:0]               o_acc
);
    import c64id_pkg::*;

    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [63:0] w_fold [0:MAX_BYTES];
    logic [3:0]  w_sel;

    assign w_fold[0] = r_acc;

    for (genvar k = 0; k < MAX_BYTES; k++) begin : g_byte
        assign w_fold[k+1] = fold_byte(w_fold[k], i_word[8*k +: 8]);
    end

    // counts above eight saturate
    assign w_sel = (i_cmd.count > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : i_cmd.count;

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.en) begin
            case (i_cmd.kind)
                KIND_START:  n_acc = CRC_INIT;
                KIND_DATA:   n_acc = w_fold[w_sel];
                KIND_FINISH: n_acc = '0;
                default:     n_acc = r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= CRC_INIT;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: rtl/c64id_fmt.sv
// formatter: turns a captured id into seventeen ascii characters
`default_nettype none

module c64id_fmt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [63:0] i_id,
    output logic             o_ready,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_id,
    output logic [6:0]       o_char,
    output logic             o_last
);
    import c64id_pkg::*;

    logic        r_busy;
    logic [4:0]  r_pos;
    logic [63:0] r_id;
    logic [6:0]  r_char;
    logic        r_last;
    logic        w_take;
    logic [4:0]  n_pos;

    assign w_take  = r_busy && i_ready;
    assign o_ready = !r_busy || (i_ready && r_last);
    assign n_pos   = r_pos + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (w_take) begin
            if (r_last) begin
                r_busy <= 1'b0;
                r_pos  <= '0;
            end else begin
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id   <= i_id;
            r_char <= fmt_char(i_id, 5'd0);
            r_last <= 1'b0;
        end else if (w_take && !r_last) begin
            r_char <= fmt_char(r_id, n_pos);
            r_last <= (n_pos == 5'(ID_CHARS - 1));
        end
    end

    assign o_valid = r_busy;
    assign o_id    = r_id;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: rtl/crc64_disc_id_engine_top.sv
// top level of the crc-64 disc id engine: input register, accumulator, formatter
`default_nettype none

// Reflected CRC-64 (polynomial 0x92C64265D32139A4) disc id engine. Items enter on
// the slave stream: tuser holds the kind (start, data, finish), tdata the data word
// and the byte count. A start sets the accumulator to all ones, a data item folds in
// 1 to 8 low bytes of the word (lowest byte first, a count of zero folds nothing,
// counts above eight act as eight), the unused kind is dropped. A finish hands the
// accumulator to the formatter and clears it; the formatter then emits 17 items on
// the master stream: upper-case hex of the id, most significant digit first, with a
// hyphen as the ninth character, each item carrying the full 64-bit id and tlast on
// the seventeenth. Rate: one item per clock on the input while no finish waits for the
// formatter; the whole byte fold is a single combinational pass between the input
// register and the accumulator. The formatter puts out one character per clock while
// the master stream takes them; a second finish waits in the input register until the
// last character of the previous id is taken, and while it waits the slave stream is
// stalled, so no start or data item gets past it. An accepted finish goes from the
// input register into the formatter once that is free, and the formatter registers
// the first character of the id as it loads.

module crc64_disc_id_engine_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  wire logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // id_value[63:0], id_char[70:64], zero pad
    output logic             o_m_axis_tlast
);
    import c64id_pkg::*;

    // input register
    logic        r_in_valid;
    t_kind       r_in_kind;
    logic [63:0] r_in_word;
    logic [3:0]  r_in_count;

    logic        w_in_take;
    logic        w_advance;
    logic        w_fmt_ready;
    logic        w_fmt_load;
    t_crc_cmd    w_cmd;
    logic [63:0] w_acc;
    logic [63:0] w_out_id;
    logic [6:0]  w_out_char;

    // a finish can only leave once the formatter is free
    assign w_advance  = r_in_valid && ((r_in_kind != KIND_FINISH) || w_fmt_ready);
    assign w_in_take  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fmt_load = w_advance && (r_in_kind == KIND_FINISH);

    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind  <= t_kind'(i_s_axis_tuser);
            r_in_word  <= i_s_axis_tdata[63:0];
            r_in_count <= i_s_axis_tdata[67:64];
        end
    end

    assign w_cmd.en    = w_advance;
    assign w_cmd.kind  = r_in_kind;
    assign w_cmd.count = r_in_count;

    c64id_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_word  (r_in_word),
        .o_acc   (w_acc)
    );

    c64id_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fmt_load),
        .i_id    (w_acc),
        .o_ready (w_fmt_ready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_id    (w_out_id),
        .o_char  (w_out_char),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_out_char, w_out_id};

endmodule

`default_nettype wire

FILE: test/crc64_disc_id_checker.sv
// checker for the crc-64 disc id engine: watches both streams, predicts every id character
module crc64_disc_id_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [71:0] i_s_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  wire logic [1:0]  i_s_tuser,   // kind[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [71:0] i_m_tdata,   // id_value[63:0], id_char[70:64], zero pad
    input  wire logic        i_m_tlast,
    output int               o_mismatches,
    output int               o_pending
);
    import c64id_pkg::*;

    typedef struct packed {
        logic [63:0] id_value;
        logic [6:0]  id_char;
        logic        last;
    } t_id_char;

    t_id_char    id_chars_q[$];
    logic [63:0] crc_model;
    int          mismatches;

    // reflected crc over the low bytes of a word, lowest byte first
    function automatic logic [63:0] crc_fold_bytes(input logic [63:0] crc,
                                                   input logic [63:0] word,
                                                   input logic [3:0]  count);
        logic [63:0] c;
        int          n;
        c = crc;
        n = (count > 4'd8) ? 8 : int'(count);
        for (int k = 0; k < 8; k++) begin
            if (k < n) begin
                c ^= {56'd0, word[8*k +: 8]};
                for (int b = 0; b < 8; b++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
        end
        return c;
    endfunction

    function automatic logic [6:0] ascii_digit(input logic [3:0] nib);
        return (nib < DIGIT_LIMIT) ? (CHAR_ZERO + 7'(nib)) : (CHAR_A + 7'(nib - DIGIT_LIMIT));
    endfunction

    always @(posedge i_clk) begin : watch
        t_id_char got;
        t_id_char want;
        int       digit;
        if (!i_rst_n) begin
            crc_model = CRC_INIT;
            id_chars_q.delete();
            mismatches = 0;
        end else begin
            // output first: a character taken now belongs to an earlier finish
            if (i_m_tvalid && i_m_tready) begin
                got.id_value = i_m_tdata[63:0];
                got.id_char  = i_m_tdata[70:64];
                got.last     = i_m_tlast;
                if (id_chars_q.size() == 0) begin
                    $error("unexpected id character %h with id %h", got.id_char, got.id_value);
                    mismatches++;
                end else begin
                    want = id_chars_q.pop_front();
                    if (got.id_value !== want.id_value) begin
                        $error("id_value: expected %h, got %h", want.id_value, got.id_value);
                        mismatches++;
                    end
                    if (got.id_char !== want.id_char) begin
                        $error("id_char: expected %h, got %h", want.id_char, got.id_char);
                        mismatches++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    KIND_START: crc_model = CRC_INIT;
                    KIND_DATA:  crc_model = crc_fold_bytes(crc_model, i_s_tdata[63:0],
                                                           i_s_tdata[67:64]);
                    KIND_FINISH: begin
                        digit = 0;
                        for (int pos = 0; pos < ID_CHARS; pos++) begin
                            want.id_value = crc_model;
                            if (pos == HYPHEN_POS) begin
                                want.id_char = CHAR_HYPHEN;
                            end else begin
                                want.id_char = ascii_digit(crc_model[63 - 4*digit -: 4]);
                                digit++;
                            end
                            want.last = (pos == ID_CHARS - 1);
                            id_chars_q.push_back(want);
                        end
                        crc_model = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= id_chars_q.size();
    end

endmodule

FILE: test/testbench.sv
// testbench top for the crc-64 disc id engine: clock, reset, item stimulus and verdict
module testbench;
    import c64id_pkg::*;

    localparam logic [1:0] KIND_SPARE     = 2'd3;   // unused kind, dropped by the block
    localparam int         RUN_ITEMS      = 94;     // counted items per random phase
    localparam int         HOLD_CYCLES    = 200;    // long receiver hold-off
    localparam int         DRAIN_CYCLES   = 25;     // quiet time after the last character
    localparam int         WATCHDOG_LIMIT = 5000;   // cycles with no item moving

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;     // data_word[63:0], byte_count[67:64], zero pad
    logic [1:0]  s_tuser  = '0;     // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // id_value[63:0], id_char[70:64], zero pad
    logic        m_tlast;

    int mismatches;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;   // bumped by the stimulus to ask for a hold-off
    int hold_seen      = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    crc64_disc_id_engine_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    crc64_disc_id_checker u_id_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stalls, or a long hold-off when the stimulus asks for one
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: any accepted item on either side restarts the count
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // byte counts: mostly legal, now and then zero or above eight
    function automatic logic [3:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 4'd0;
        if (r < 14) return 4'($urandom_range(15, 9));
        return 4'($urandom_range(8, 1));
    endfunction

    // data words: mostly random, sometimes the extremes
    function automatic logic [63:0] pick_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    // offer one item, with random idle cycles ahead of it, and wait for its handshake;
    // valid stays high across back-to-back items so it is never dropped and raised in one step
    task automatic push_item(input logic [1:0] kind, input logic [63:0] word,
                             input logic [3:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, count, word};
        do @(posedge clk); while (!s_tready);
        if (kind != KIND_SPARE) items_sent++;
    endtask

    // one well-formed id: start, a few data items, finish
    task automatic send_id_run();
        int n;
        n = $urandom_range(6, 1);
        push_item(KIND_START, pick_word(), pick_count());
        repeat (n) push_item(KIND_DATA, pick_word(), pick_count());
        push_item(KIND_FINISH, pick_word(), pick_count());
    endtask

    // sender goes quiet until every predicted character has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = items_sent + RUN_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80) begin
                send_id_run();
            end else begin
                // noise: any kind including the unused one, any fields
                push_item(2'($urandom_range(3)), pick_word(), 4'($urandom_range(15)));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed items: extremes of the fields and the odd cases
        push_item(KIND_START, '0, 4'd0);
        push_item(KIND_DATA, '1, 4'd8);
        push_item(KIND_DATA, '0, 4'd8);
        push_item(KIND_DATA, 64'h0123_4567_89AB_CDEF, 4'd1);
        push_item(KIND_DATA, 64'hFEDC_BA98_7654_3210, 4'd4);
        push_item(KIND_DATA, '1, 4'd0);                        // zero count folds nothing
        push_item(KIND_DATA, 64'hA5A5_A5A5_5A5A_5A5A, 4'd9);   // count saturates at eight
        push_item(KIND_DATA, 64'h5A5A_5A5A_A5A5_A5A5, 4'd15);
        push_item(KIND_FINISH, '0, 4'd0);
        push_item(KIND_FINISH, '1, 4'd15);                     // finish without start: zero id
        push_item(KIND_DATA, 64'h8000_0000_0000_0001, 4'd7);   // data folds into the zero crc
        push_item(KIND_FINISH, 64'h0F0F_0F0F_0F0F_0F0F, 4'd3);
        push_item(KIND_SPARE, '1, 4'd15);                      // unused kind is dropped
        push_item(KIND_START, '1, 4'd15);
        push_item(KIND_FINISH, '0, 4'd0);                      // id of all ones
        push_item(KIND_START, '0, 4'd0);
        push_item(KIND_DATA, 64'h0000_0000_0000_0000, 4'd1);
        push_item(KIND_FINISH, '0, 4'd0);
        wait_drained();

        // random phases, no idling first
        run_phase(0, 0);

        // receiver holds off while the sender keeps pushing ids, so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        repeat (3) send_id_run();
        wait_drained();

        run_phase(73, 0);
        run_phase(0, 73);
        run_phase(12, 12);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
